// ===== sv/cdcacm_pkg.sv =====
// Shared types and constants for the CDC-ACM endpoint-0 request handler.
// No dependencies; used by the top level and its checker.
package cdcacm_pkg;

    // Result beat response codes
    typedef enum logic [1:0] {
        RSP_NONE  = 2'd0,
        RSP_DATA  = 2'd1,
        RSP_ACK   = 2'd2,
        RSP_STALL = 2'd3
    } rsp_t;

    typedef enum logic [1:0] {
        HALT_NONE  = 2'd0,
        HALT_CLEAR = 2'd1,
        HALT_SET   = 2'd2
    } halt_t;

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_OPEN  = 2'd1,
        EVT_CLOSE = 2'd2
    } port_evt_t;

    // Configuration register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_FUNCTION_ENABLE = 3'd0,
        REG_COMM_INTERFACE  = 3'd1,
        REG_NOTIFY_ADDR     = 3'd2,
        REG_BULK_IN_ADDR    = 3'd3,
        REG_BULK_OUT_ADDR   = 3'd4,
        REG_NOTIFY_HANDLE   = 3'd5,
        REG_BULK_IN_HANDLE  = 3'd6,
        REG_BULK_OUT_HANDLE = 3'd7
    } reg_idx_t;

    // bmRequestType fields
    localparam logic [1:0] TYPE_STANDARD = 2'd0;
    localparam logic [1:0] TYPE_CLASS    = 2'd1;
    localparam logic [4:0] RECIP_IFACE   = 5'd1;
    localparam logic [4:0] RECIP_EP      = 5'd2;

    // bRequest codes
    localparam logic [7:0] REQ_GET_STATUS      = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE   = 8'h01;
    localparam logic [7:0] REQ_SET_FEATURE     = 8'h03;
    localparam logic [7:0] REQ_GET_INTERFACE   = 8'h0a;
    localparam logic [7:0] REQ_SET_INTERFACE   = 8'h0b;
    localparam logic [7:0] REQ_SET_LINE_CODING = 8'h20;
    localparam logic [7:0] REQ_GET_LINE_CODING = 8'h21;
    localparam logic [7:0] REQ_SET_CTRL_LINE   = 8'h22;

    localparam logic [7:0] IFACE_UNASSIGNED = 8'hff;

    localparam logic [2:0] LEN_STATUS     = 3'd2;
    localparam logic [2:0] LEN_INTERFACE  = 3'd1;
    localparam logic [2:0] LEN_LINE_CODE  = 3'd7;

    // Decoded response of one input item
    typedef struct packed {
        rsp_t       rsp;
        logic       is_data;   // data reply with at least one byte
        logic       lc_src;    // bytes come from the line coding table
        logic [2:0] nbytes;    // truncated byte count
        halt_t      halt;
        logic [4:0] hep;
        port_evt_t  evt;
        logic       dtr;
        logic       seen;
    } dec_t;

    // 115200 baud, 1 stop bit, no parity, 8 data bits
    function automatic logic [7:0] line_coding_byte(input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = 8'h00;
            3'd1:    b = 8'hc2;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h00;
            3'd5:    b = 8'h00;
            3'd6:    b = 8'h08;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/cdc_acm_control_request_handler_top.sv =====
// CDC-ACM endpoint-0 request handler: top level.
// Depends on cdcacm_pkg.
//
// Usage:
//  - Slave stream takes one setup packet (s_tuser = 0) or one class reset
//    (s_tuser = 1) per beat. Class reset clears the DTR tracking state.
//  - Master stream gives the result beats of each item: a single beat for
//    not-claimed / acknowledge / stall / empty data reply, or one beat per
//    reply byte (up to 7, cut to wLength). m_tlast marks the item's final beat.
//  - APB port holds the eight configuration registers at 4*index; pready is
//    tied high, a write lands at the access cycle, reads return the value.
// Timing:
//  - Input register, then decode and beat select, then output register.
//    Beats load into the output register whenever it is empty or its beat is taken.
//  - An item holds the input register until its last beat (of 1 to 7) loads;
//    unless the receiver stalls, one result beat leaves per cycle, set by the
//    byte counter walking the reply. The next item is taken in the cycle its
//    predecessor's last beat loads, so single-beat items stream at one per cycle.
//  - DTR state is updated when an item's last beat loads into the output reg.
// Reset: all control state cleared, registers to their reset values, both
//  streams empty. When the receiver stalls the output register holds its
//  beat, the counter stops, and s_tready falls once the input register is full.
module cdc_acm_control_request_handler_top (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // request_type[7:0], request[15:8], request_value[31:16],
    // request_index[47:32], request_length[63:48]
    input  logic [63:0] s_tdata,
    // action[0]
    input  logic        s_tuser,
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // response[1:0], data_valid[2], data_byte[10:3], halt_command[12:11],
    // halt_ep_handle[17:13], port_event[19:18], dtr_level[20], zero[23:21]
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration ----------------
    logic       fn_en_reg;
    logic [7:0] comm_if_reg;
    logic [7:0] notify_addr_reg;
    logic [7:0] bulk_in_addr_reg;
    logic [7:0] bulk_out_addr_reg;
    logic [5:0] notify_hdl_reg;
    logic [5:0] bulk_in_hdl_reg;
    logic [5:0] bulk_out_hdl_reg;

    logic                  cfg_wr;
    cdcacm_pkg::reg_idx_t  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = cdcacm_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fn_en_reg         <= 1'b0;
            comm_if_reg       <= cdcacm_pkg::IFACE_UNASSIGNED;
            notify_addr_reg   <= 8'h00;
            bulk_in_addr_reg  <= 8'h00;
            bulk_out_addr_reg <= 8'h00;
            notify_hdl_reg    <= 6'h3f;
            bulk_in_hdl_reg   <= 6'h3f;
            bulk_out_hdl_reg  <= 6'h3f;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                cdcacm_pkg::REG_FUNCTION_ENABLE: fn_en_reg         <= pwdata[0];
                cdcacm_pkg::REG_COMM_INTERFACE:  comm_if_reg       <= pwdata[7:0];
                cdcacm_pkg::REG_NOTIFY_ADDR:     notify_addr_reg   <= pwdata[7:0];
                cdcacm_pkg::REG_BULK_IN_ADDR:    bulk_in_addr_reg  <= pwdata[7:0];
                cdcacm_pkg::REG_BULK_OUT_ADDR:   bulk_out_addr_reg <= pwdata[7:0];
                cdcacm_pkg::REG_NOTIFY_HANDLE:   notify_hdl_reg    <= pwdata[5:0];
                cdcacm_pkg::REG_BULK_IN_HANDLE:  bulk_in_hdl_reg   <= pwdata[5:0];
                cdcacm_pkg::REG_BULK_OUT_HANDLE: bulk_out_hdl_reg  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            cdcacm_pkg::REG_FUNCTION_ENABLE: prdata = {31'd0, fn_en_reg};
            cdcacm_pkg::REG_COMM_INTERFACE:  prdata = {24'd0, comm_if_reg};
            cdcacm_pkg::REG_NOTIFY_ADDR:     prdata = {24'd0, notify_addr_reg};
            cdcacm_pkg::REG_BULK_IN_ADDR:    prdata = {24'd0, bulk_in_addr_reg};
            cdcacm_pkg::REG_BULK_OUT_ADDR:   prdata = {24'd0, bulk_out_addr_reg};
            cdcacm_pkg::REG_NOTIFY_HANDLE:   prdata = {26'd0, notify_hdl_reg};
            cdcacm_pkg::REG_BULK_IN_HANDLE:  prdata = {26'd0, bulk_in_hdl_reg};
            cdcacm_pkg::REG_BULK_OUT_HANDLE: prdata = {26'd0, bulk_out_hdl_reg};
            default:                         prdata = 32'd0;
        endcase
    end

    // ---------------- input register ----------------
    logic        in_valid_reg;
    logic        act_reg;
    logic [7:0]  rtype_reg;
    logic [7:0]  req_reg;
    logic [15:0] wval_reg;
    logic [7:0]  idx_reg;     // only the low byte of wIndex is ever decoded
    logic [15:0] wlen_reg;

    logic in_take;
    logic load;
    logic beat_last;
    logic retire;

    assign in_take  = s_tvalid & s_tready;
    assign retire   = load & beat_last;
    assign s_tready = ~in_valid_reg | retire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (retire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            act_reg   <= s_tuser;
            rtype_reg <= s_tdata[7:0];
            req_reg   <= s_tdata[15:8];
            wval_reg  <= s_tdata[31:16];
            idx_reg   <= s_tdata[39:32];
            wlen_reg  <= s_tdata[63:48];
        end
    end

    // ---------------- DTR tracking ----------------
    logic dtr_reg;
    logic seen_reg;

    // ---------------- decode ----------------
    cdcacm_pkg::dec_t dec;
    logic [4:0] recip;
    logic [1:0] rtyp;
    logic       dir_in;
    logic [7:0] data_if;
    logic       if_hit;
    logic       ep_hit;
    logic [5:0] ep_hdl;
    logic [2:0] full_len;
    logic       want_data;
    logic       dtr_bit;

    assign recip   = rtype_reg[4:0];
    assign rtyp    = rtype_reg[6:5];
    assign dir_in  = rtype_reg[7];
    assign data_if = comm_if_reg + 8'd1;
    assign if_hit  = (comm_if_reg != cdcacm_pkg::IFACE_UNASSIGNED)
                   && ((idx_reg == comm_if_reg) || (idx_reg == data_if));
    assign dtr_bit = wval_reg[0];

    // first matching endpoint address wins
    always_comb
    begin
        ep_hit = 1'b1;
        ep_hdl = notify_hdl_reg;
        if (idx_reg == notify_addr_reg)
        begin
            ep_hdl = notify_hdl_reg;
        end
        else if (idx_reg == bulk_in_addr_reg)
        begin
            ep_hdl = bulk_in_hdl_reg;
        end
        else if (idx_reg == bulk_out_addr_reg)
        begin
            ep_hdl = bulk_out_hdl_reg;
        end
        else
        begin
            ep_hit = 1'b0;
        end
    end

    always_comb
    begin
        dec        = '0;
        dec.rsp    = cdcacm_pkg::RSP_NONE;
        dec.halt   = cdcacm_pkg::HALT_NONE;
        dec.evt    = cdcacm_pkg::EVT_NONE;
        dec.dtr    = dtr_reg;
        dec.seen   = seen_reg;
        full_len   = 3'd0;
        want_data  = 1'b0;

        if (act_reg)
        begin
            dec.dtr  = 1'b0;
            dec.seen = 1'b0;
        end
        else if (!fn_en_reg)
        begin
            dec.rsp = cdcacm_pkg::RSP_NONE;
        end
        else if (recip == cdcacm_pkg::RECIP_IFACE)
        begin
            if (!if_hit)
            begin
                dec.rsp = cdcacm_pkg::RSP_NONE;
            end
            else if (rtyp == cdcacm_pkg::TYPE_STANDARD)
            begin
                if (req_reg == cdcacm_pkg::REQ_GET_STATUS)
                begin
                    want_data = 1'b1;
                    full_len  = cdcacm_pkg::LEN_STATUS;
                end
                else if (req_reg == cdcacm_pkg::REQ_GET_INTERFACE)
                begin
                    want_data = 1'b1;
                    full_len  = cdcacm_pkg::LEN_INTERFACE;
                end
                else if (req_reg inside {cdcacm_pkg::REQ_CLEAR_FEATURE,
                                         cdcacm_pkg::REQ_SET_FEATURE,
                                         cdcacm_pkg::REQ_SET_INTERFACE})
                begin
                    dec.rsp = cdcacm_pkg::RSP_ACK;
                end
                else
                begin
                    dec.rsp = cdcacm_pkg::RSP_STALL;
                end
            end
            else if (rtyp == cdcacm_pkg::TYPE_CLASS)
            begin
                if (req_reg == cdcacm_pkg::REQ_SET_LINE_CODING)
                begin
                    dec.rsp = cdcacm_pkg::RSP_STALL;
                end
                else if (req_reg == cdcacm_pkg::REQ_GET_LINE_CODING)
                begin
                    want_data  = 1'b1;
                    dec.lc_src = 1'b1;
                    full_len   = cdcacm_pkg::LEN_LINE_CODE;
                end
                else if (req_reg == cdcacm_pkg::REQ_SET_CTRL_LINE)
                begin
                    dec.rsp = cdcacm_pkg::RSP_ACK;
                    if ((dtr_bit != dtr_reg) || !seen_reg)
                    begin
                        dec.evt = dtr_bit ? cdcacm_pkg::EVT_OPEN : cdcacm_pkg::EVT_CLOSE;
                    end
                    dec.dtr  = dtr_bit;
                    dec.seen = 1'b1;
                end
                else
                begin
                    dec.rsp = dir_in ? cdcacm_pkg::RSP_STALL : cdcacm_pkg::RSP_ACK;
                end
            end
            else
            begin
                dec.rsp = cdcacm_pkg::RSP_STALL;
            end
        end
        else if (recip == cdcacm_pkg::RECIP_EP)
        begin
            if (!ep_hit)
            begin
                dec.rsp = cdcacm_pkg::RSP_NONE;
            end
            else if (rtyp != cdcacm_pkg::TYPE_STANDARD)
            begin
                dec.rsp = cdcacm_pkg::RSP_STALL;
            end
            else if (req_reg == cdcacm_pkg::REQ_GET_STATUS)
            begin
                want_data = 1'b1;
                full_len  = cdcacm_pkg::LEN_STATUS;
            end
            else if ((req_reg == cdcacm_pkg::REQ_CLEAR_FEATURE)
                  || (req_reg == cdcacm_pkg::REQ_SET_FEATURE))
            begin
                dec.rsp = cdcacm_pkg::RSP_ACK;
                // halt only for ENDPOINT_HALT on an enabled endpoint
                if ((wval_reg == 16'd0) && !ep_hdl[5])
                begin
                    dec.halt = (req_reg == cdcacm_pkg::REQ_CLEAR_FEATURE)
                             ? cdcacm_pkg::HALT_CLEAR : cdcacm_pkg::HALT_SET;
                    dec.hep  = ep_hdl[4:0];
                end
            end
            else
            begin
                dec.rsp = cdcacm_pkg::RSP_STALL;
            end
        end

        if (want_data)
        begin
            dec.rsp    = cdcacm_pkg::RSP_DATA;
            // cut to wLength
            dec.nbytes = (wlen_reg < {13'd0, full_len}) ? wlen_reg[2:0] : full_len;
            dec.is_data = (dec.nbytes != 3'd0);
        end
    end

    // ---------------- beat sequencing ----------------
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic [7:0]  beat_byte;
    logic [23:0] beat_tdata;

    assign beat_last = ~dec.is_data | (cnt_reg == (dec.nbytes - 3'd1));
    assign beat_byte = dec.lc_src ? cdcacm_pkg::line_coding_byte(cnt_reg) : 8'h00;

    always_comb
    begin
        if (dec.is_data)
        begin
            // reply bytes carry no halt or event; DTR is unchanged
            beat_tdata = {3'd0, dtr_reg, cdcacm_pkg::EVT_NONE, 5'd0,
                          cdcacm_pkg::HALT_NONE, beat_byte, 1'b1,
                          cdcacm_pkg::RSP_DATA};
        end
        else
        begin
            beat_tdata = {3'd0, dec.dtr, dec.evt, dec.hep, dec.halt, 8'h00, 1'b0,
                          dec.rsp};
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (retire)
        begin
            cnt_next = 3'd0;
        end
        else if (load)
        begin
            cnt_next = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            dtr_reg  <= 1'b0;
            seen_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (retire)
            begin
                dtr_reg  <= dec.dtr;
                seen_reg <= dec.seen;
            end
        end
    end

    // ---------------- output register ----------------
    logic        out_valid_reg;
    logic [23:0] out_tdata_reg;
    logic        out_last_reg;

    assign load = in_valid_reg & (~out_valid_reg | m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_tdata_reg <= beat_tdata;
            out_last_reg  <= beat_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/cdcacm_checker.sv =====
// Port-level checks for the CDC-ACM request handler result stream.
// Depends on cdcacm_pkg; bound to cdc_acm_control_request_handler_top.
module cdcacm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // a beat without a reply byte carries a zero byte and ends its item
    a_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> (m_tdata[10:3] == 8'd0) && m_tlast)
        else $error("non-data beat malformed");

    // reply bytes only in data replies, with no halt or event
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |->
            (m_tdata[1:0] == cdcacm_pkg::RSP_DATA) && (m_tdata[19:11] == 9'd0))
        else $error("data beat malformed");

    // halt commands only go with an acknowledge
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[12:11] != cdcacm_pkg::HALT_NONE) |->
            (m_tdata[1:0] == cdcacm_pkg::RSP_ACK))
        else $error("halt command without acknowledge");

    // port events only go with an acknowledge and no halt command
    a_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[19:18] != cdcacm_pkg::EVT_NONE) |->
            (m_tdata[1:0] == cdcacm_pkg::RSP_ACK) && (m_tdata[12:11] == cdcacm_pkg::HALT_NONE))
        else $error("port event on wrong response");

endmodule

bind cdc_acm_control_request_handler_top cdcacm_checker u_cdcacm_checker (.*);
